// ----- rtl/core/sfir_pkg.sv -----
package sfir_pkg;

  localparam int SampleW = 16;
  localparam int CoefW   = 18;
  localparam int NumCoef = 8;
  localparam int CfgIdxW = 3;
  localparam int FracW   = 16;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [CoefW-1:0]   coef_t;

  localparam coef_t CoefCenterReset = 18'sd65536;
  localparam coef_t CoefOffReset    = 18'sd0;

  localparam sample_t SampleMax = 16'sh7fff;
  localparam sample_t SampleMin = 16'sh8000;

  typedef struct packed {
    sample_t sample_in;
    logic    last_in;
  } in_t;

  typedef struct packed {
    sample_t sample_out;
    logic    last_out;
  } out_t;

  typedef struct packed {
    logic valid;
    logic last;
  } tap_ctrl_t;

endpackage

// ----- rtl/core/sfir_mac.sv -----
module sfir_mac #(
  parameter int HALF_TAPS = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  sfir_pkg::tap_ctrl_t tap_i,
  input  sfir_pkg::sample_t   hist_i [2*HALF_TAPS+1],
  input  sfir_pkg::coef_t     coef_i [sfir_pkg::NumCoef],
  output logic                res_valid_o,
  output sfir_pkg::out_t      res_o
);
  import sfir_pkg::*;

  localparam int NProd = HALF_TAPS + 1;
  localparam int ProdW = SampleW + 1 + CoefW;
  localparam int NPart = (NProd + 1) / 2;
  localparam int PartW = ProdW + 1;
  localparam int AccW  = ProdW + $clog2(NProd);
  localparam int RndW  = AccW - FracW;

  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [PartW-1:0] part_t;

  prod_t     prod_d [NProd];
  prod_t     prod_q [NProd];
  part_t     part_d [NPart];
  part_t     part_q [NPart];
  tap_ctrl_t ctl1_q, ctl2_q;

  logic signed [AccW-1:0] acc;
  logic signed [AccW-1:0] biased;
  logic signed [RndW-1:0] rnd;
  sample_t                sat;
  logic                   res_valid_q;
  out_t                   res_q;

  // pre-add symmetric pairs, one multiplier per coefficient
  for (genvar k = 0; k < NProd; k++) begin : g_prod
    logic signed [SampleW:0] pair;
    if (k == 0) begin : g_center
      assign pair = (SampleW+1)'(hist_i[HALF_TAPS]);
    end else begin : g_side
      assign pair = (SampleW+1)'(hist_i[HALF_TAPS-k]) + (SampleW+1)'(hist_i[HALF_TAPS+k]);
    end
    assign prod_d[k] = ProdW'(coef_i[k]) * ProdW'(pair);
  end

  // first level of the adder tree
  for (genvar j = 0; j < NPart; j++) begin : g_part
    if (2*j+1 < NProd) begin : g_two
      assign part_d[j] = PartW'(prod_q[2*j]) + PartW'(prod_q[2*j+1]);
    end else begin : g_one
      assign part_d[j] = PartW'(prod_q[2*j]);
    end
  end

  always_comb begin
    acc = '0;
    for (int j = 0; j < NPart; j++) begin
      acc = acc + AccW'(part_q[j]);
    end
    biased = acc + AccW'(32768);
    rnd    = RndW'(biased >>> FracW);
    if (rnd > RndW'(SampleMax)) begin
      sat = SampleMax;
    end else if (rnd < RndW'(SampleMin)) begin
      sat = SampleMin;
    end else begin
      sat = SampleW'(rnd);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q      <= '0;
      ctl2_q      <= '0;
      res_valid_q <= 1'b0;
    end else if (adv_i) begin
      ctl1_q      <= tap_i;
      ctl2_q      <= ctl1_q;
      res_valid_q <= ctl2_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q         <= prod_d;
      part_q         <= part_d;
      res_q.sample_out <= sat;
      res_q.last_out   <= ctl2_q.last;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/core/symmetric_fir_filter_replicate_border_unit.sv -----
// Symmetric FIR filter with 2*HALF_TAPS+1 taps over a stream of signed 16-bit samples,
// coefficients in Q2.16 written through the register port (index 0 center, 1..7 offsets).
// The first sample of a signal fills the older history and the marked last sample is
// repeated to flush the final outputs, so a signal of n samples gives n results, the
// last one flagged. One sample is taken per cycle unless the output stall or a flush holds
// the input; after a last sample the input stalls while the flush runs through the history
// shift register. A result is registered in turn in the history, multiply, partial sum and
// output registers, rounded half up and saturated to 16 bits; output stall holds the whole
// pipeline.
module symmetric_fir_filter_replicate_border_unit #(
  parameter int HALF_TAPS = 7
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  sfir_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output sfir_pkg::out_t                 out_data_o,
  input  logic                           cfg_we_i,
  input  logic [sfir_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sfir_pkg::CoefW-1:0]     cfg_data_i
);
  import sfir_pkg::*;

  localparam int NTaps = 2 * HALF_TAPS + 1;
  localparam int CntW  = $clog2(HALF_TAPS + 1);
  localparam logic [CntW-1:0] HalfCnt = CntW'(HALF_TAPS);
  localparam logic [CntW-1:0] OneCnt  = CntW'(1);

  sample_t         hist_d [NTaps];
  sample_t         hist_q [NTaps];
  coef_t           coef_q [NumCoef];
  logic [CntW-1:0] fill_d, fill_q;
  logic [CntW-1:0] rem_d, rem_q;
  logic [CntW-1:0] have_d, have_q;
  logic [CntW-1:0] fill_next;
  tap_ctrl_t       tap_d, tap_q;
  logic            adv;
  logic            accept;
  logic            res_valid;
  out_t            res;

  assign adv        = !(res_valid && out_stall_i);
  assign in_stall_o = !adv || (rem_q != '0);
  assign accept     = in_valid_i && !in_stall_o;
  assign fill_next  = (fill_q == HalfCnt) ? fill_q : fill_q + OneCnt;

  always_comb begin
    hist_d = hist_q;
    fill_d = fill_q;
    rem_d  = rem_q;
    have_d = have_q;
    tap_d  = tap_q;
    if (adv) begin
      tap_d = '0;
      if (rem_q != '0) begin
        // flush: repeat the last sample
        for (int i = 0; i < NTaps - 1; i++) begin
          hist_d[i] = hist_q[i+1];
        end
        tap_d.valid = (rem_q <= have_q);
        tap_d.last  = (rem_q == OneCnt);
        rem_d       = rem_q - OneCnt;
      end else if (accept) begin
        if (fill_q == '0) begin
          for (int i = 0; i < NTaps; i++) begin
            hist_d[i] = in_data_i.sample_in;
          end
        end else begin
          for (int i = 0; i < NTaps - 1; i++) begin
            hist_d[i] = hist_q[i+1];
          end
          hist_d[NTaps-1] = in_data_i.sample_in;
        end
        tap_d.valid = (fill_q == HalfCnt);
        fill_d      = fill_next;
        if (in_data_i.last_in) begin
          rem_d  = HalfCnt;
          have_d = fill_next;
          fill_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      rem_q  <= '0;
      have_q <= '0;
      tap_q  <= '0;
    end else begin
      fill_q <= fill_d;
      rem_q  <= rem_d;
      have_q <= have_d;
      tap_q  <= tap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hist_q <= hist_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= CoefCenterReset;
      for (int i = 1; i < NumCoef; i++) begin
        coef_q[i] <= CoefOffReset;
      end
    end else if (cfg_we_i) begin
      coef_q[cfg_idx_i] <= coef_t'(cfg_data_i);
    end
  end

  sfir_mac #(
    .HALF_TAPS(HALF_TAPS)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .tap_i      (tap_q),
    .hist_i     (hist_q),
    .coef_i     (coef_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  assign out_valid_o = res_valid;
  assign out_data_o  = res;

endmodule

// ----- tb/tb_symmetric_fir_filter_replicate_border_unit.sv -----
module tb_symmetric_fir_filter_replicate_border_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sfir_pkg::*;

  localparam int HalfTaps    = 7;
  localparam int NumTaps     = 2 * HalfTaps + 1;
  localparam int DrainCycles = 24;
  localparam int HoldCycles  = 300;
  localparam int CycleLimit  = 200000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_t                in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  out_t               out_data;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CoefW-1:0]   cfg_data = '0;

  in_t     sample_q[$];
  out_t    filtered_q[$];
  sample_t fir_hist[NumTaps];
  int      fir_fill;
  coef_t   fir_coef[NumCoef];

  int unsigned send_gap = 0;
  int unsigned recv_wait = 0;
  int unsigned hold_left = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  logic        send_idle = 1'b0;
  logic        recv_idle = 1'b0;
  int          mismatches = 0;
  int          cycles = 0;

  symmetric_fir_filter_replicate_border_unit #(
    .HALF_TAPS(HalfTaps)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // filter model
  function automatic sample_t fir_output();
    longint acc;
    longint q;
    acc = longint'(fir_coef[0]) * longint'(fir_hist[HalfTaps]);
    for (int k = 1; k <= HalfTaps; k++) begin
      acc += longint'(fir_coef[k]) *
             (longint'(fir_hist[HalfTaps-k]) + longint'(fir_hist[HalfTaps+k]));
    end
    q = (acc + 64'sd32768) >>> 16;
    if (q > 32767) return SampleMax;
    if (q < -32768) return SampleMin;
    return sample_t'(q);
  endfunction

  function automatic void shift_in(sample_t s);
    for (int i = 0; i < NumTaps - 1; i++) fir_hist[i] = fir_hist[i+1];
    fir_hist[NumTaps-1] = s;
  endfunction

  function automatic void filter_sample(in_t it);
    int have;
    out_t res;
    if (fir_fill == 0) begin
      for (int i = 0; i < NumTaps; i++) fir_hist[i] = it.sample_in;
    end else begin
      shift_in(it.sample_in);
    end
    if (fir_fill >= HalfTaps) begin
      res.sample_out = fir_output();
      res.last_out   = 1'b0;
      filtered_q.push_back(res);
    end
    if (fir_fill < HalfTaps) fir_fill++;
    if (it.last_in) begin
      have = fir_fill;
      // flush by repeating the last sample
      for (int j = 1; j <= HalfTaps; j++) begin
        shift_in(it.sample_in);
        if (j >= HalfTaps - have + 1) begin
          res.sample_out = fir_output();
          res.last_out   = (j == HalfTaps);
          filtered_q.push_back(res);
        end
      end
      fir_fill = 0;
    end
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 7))
      0: return SampleMax;
      1: return SampleMin;
      2: return sample_t'($urandom_range(0, 64)) - 16'sd32;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic coef_t rand_coef();
    case ($urandom_range(0, 5))
      0: return 18'sh1ffff;
      1: return 18'sh20000;
      2: return coef_t'($urandom_range(0, 16384)) - 18'sd8192;
      default: return coef_t'($urandom);
    endcase
  endfunction

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) filter_sample(in_data);
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          in_data  <= sample_q.pop_front();
          in_valid <= 1'b1;
          send_gap <= send_idle ? $urandom_range(0, 5) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk or negedge rst_n) begin : monitor
    int unsigned w;
    out_t want;
    if (!rst_n) begin
      out_stall <= 1'b1;
      recv_wait <= 0;
    end else begin
      w = recv_wait;
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transaction: sample_out %0d last_out %0b",
                     out_data.sample_out, out_data.last_out);
        end else begin
          want = filtered_q.pop_front();
          if (out_data.sample_out !== want.sample_out ||
              out_data.last_out !== want.last_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: sample_out exp %0d got %0d, last_out exp %0b got %0b",
                       want.sample_out, out_data.sample_out,
                       want.last_out, out_data.last_out);
          end
        end
        w = recv_idle ? $urandom_range(0, 5) : 0;
      end else if (w != 0) begin
        w--;
      end
      recv_wait <= w;
      out_stall <= (hold_left != 0) || (w != 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic load_coefs(input coef_t vals[NumCoef]);
    for (int i = 0; i < NumCoef; i++) begin
      @(posedge clk);
      cfg_we   <= 1'b1;
      cfg_idx  <= i[CfgIdxW-1:0];
      cfg_data <= vals[i];
      fir_coef[i] = vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_signal(input int len, input bit closed);
    in_t it;
    for (int i = 0; i < len; i++) begin
      it.sample_in = rand_sample();
      it.last_in   = closed && (i == len - 1);
      sample_q.push_back(it);
    end
  endtask

  task automatic push_random(input int count, input bit close_end);
    int len;
    while (count > 0) begin
      len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : $urandom_range(9, 24);
      if (len > count) len = count;
      count -= len;
      push_signal(len, (count != 0) || close_end || ($urandom_range(0, 3) != 0));
    end
  endtask

  task automatic drain();
    do @(posedge clk);
    while (sample_q.size() != 0 || in_valid || filtered_q.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    coef_t vals[NumCoef];
    in_t   it;
    fir_coef[0] = CoefCenterReset;
    for (int i = 1; i < NumCoef; i++) fir_coef[i] = CoefOffReset;
    for (int i = 0; i < NumTaps; i++) fir_hist[i] = '0;
    fir_fill = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset coefficients: one-sample, short and just-full signals
    @(posedge clk);
    send_idle <= 1'b1;
    recv_idle <= 1'b1;
    sample_q.push_back('{sample_in: SampleMax, last_in: 1'b1});
    sample_q.push_back('{sample_in: SampleMin, last_in: 1'b1});
    sample_q.push_back('{sample_in: 16'sd0, last_in: 1'b0});
    sample_q.push_back('{sample_in: -16'sd1, last_in: 1'b0});
    sample_q.push_back('{sample_in: 16'sd1, last_in: 1'b1});
    for (int i = 0; i < HalfTaps + 1; i++) begin
      it.sample_in = i[0] ? SampleMin : SampleMax;
      it.last_in   = (i == HalfTaps);
      sample_q.push_back(it);
    end
    drain();

    // all coefficients at maximum, saturation
    for (int i = 0; i < NumCoef; i++) vals[i] = 18'sh1ffff;
    load_coefs(vals);
    for (int i = 0; i < HalfTaps + 3; i++) begin
      it.sample_in = (i < 5) ? SampleMax : SampleMin;
      it.last_in   = (i == HalfTaps + 2);
      sample_q.push_back(it);
    end
    drain();

    // all coefficients at minimum, no idling
    for (int i = 0; i < NumCoef; i++) vals[i] = 18'sh20000;
    load_coefs(vals);
    send_idle <= 1'b0;
    recv_idle <= 1'b0;
    push_random(40, 1'b0);
    drain();

    // random coefficients with a long output hold-off
    for (int i = 0; i < NumCoef; i++) vals[i] = rand_coef();
    load_coefs(vals);
    recv_idle <= 1'b1;
    hold_req  <= 1'b1;
    push_random(50, 1'b0);
    drain();

    // mild low-pass style coefficients
    vals[0] = CoefCenterReset;
    for (int i = 1; i < NumCoef; i++) vals[i] = coef_t'($urandom_range(0, 8192)) - 18'sd2048;
    load_coefs(vals);
    send_idle <= 1'b1;
    push_random(50, 1'b0);
    drain();

    // random coefficients, everything closed out
    for (int i = 0; i < NumCoef; i++) vals[i] = rand_coef();
    load_coefs(vals);
    push_random(60, 1'b1);
    drain();

    if (mismatches == 0 && filtered_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
